// File: src/chacha20_stream_cipher_macros.svh
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_macros
// Assertion helpers for the stream cipher modules; only cc20_back includes them.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_CIPHER_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_MACROS_SVH

// same-cycle implication, checked on every clock outside reset
`define CC20_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define CC20_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// Types, constants and state helpers for the ChaCha20 stream cipher.
// ----------------------------------------------------------------------------
package cc20_pkg;

	localparam int unsigned ROUND_COUNT_DEF = 20;
	localparam int unsigned QUEUE_DEPTH     = 4;

	// block constant words
	localparam logic [31:0] SIGMA_0 = 32'h61707865;
	localparam logic [31:0] SIGMA_1 = 32'h3320646e;
	localparam logic [31:0] SIGMA_2 = 32'h79622d32;
	localparam logic [31:0] SIGMA_3 = 32'h6b206574;

	// quarter-round rotate amounts
	localparam int unsigned ROT_A = 16;
	localparam int unsigned ROT_B = 12;
	localparam int unsigned ROT_C = 8;
	localparam int unsigned ROT_D = 7;

	// register map indexes
	localparam logic [2:0] REG_KEY_PART_0      = 3'd0;
	localparam logic [2:0] REG_KEY_PART_1      = 3'd1;
	localparam logic [2:0] REG_KEY_PART_2      = 3'd2;
	localparam logic [2:0] REG_KEY_PART_3      = 3'd3;
	localparam logic [2:0] REG_NONCE_LOW       = 3'd4;
	localparam logic [2:0] REG_NONCE_HIGH      = 3'd5;
	localparam logic [2:0] REG_INITIAL_COUNTER = 3'd6;

	typedef logic [31:0] word_t;
	typedef word_t [15:0] blk_t;

	typedef struct packed {
		word_t plaintext_word;
		logic  restart;
	} item_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} qr_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	function automatic word_t rotl(input word_t x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// half a quarter-round: the 16/12 pair, or the 8/7 pair when second is set
	function automatic qr_t qr_half(input qr_t v, input logic second);
		qr_t r;
		r = v;
		r.a = v.a + v.b;
		r.d = second ? rotl(v.d ^ r.a, ROT_C) : rotl(v.d ^ r.a, ROT_A);
		r.c = v.c + r.d;
		r.b = second ? rotl(v.b ^ r.c, ROT_D) : rotl(v.b ^ r.c, ROT_B);
		return r;
	endfunction

	// starting state: constants, key, counter, nonce
	function automatic blk_t build_state(input logic [255:0] key, input logic [95:0] nonce,
			input word_t ctr);
		blk_t s;
		s[0] = SIGMA_0;
		s[1] = SIGMA_1;
		s[2] = SIGMA_2;
		s[3] = SIGMA_3;
		for (int i = 0; i < 8; i++) begin
			s[4 + i] = key[32*i +: 32];
		end
		s[12] = ctr;
		for (int i = 0; i < 3; i++) begin
			s[13 + i] = nonce[32*i +: 32];
		end
		return s;
	endfunction

endpackage

// File: src/cc20_front.sv
// ----------------------------------------------------------------------------
// cc20_front
// Input side: takes words from the input channel into a short queue.
// ----------------------------------------------------------------------------
module cc20_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cc20_pkg::word_t  plaintext_word,
	input  logic             restart,
	output logic             head_valid,
	output cc20_pkg::item_t  head,
	input  logic             pop
);

	localparam int unsigned PTR_W = $clog2(cc20_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(cc20_pkg::QUEUE_DEPTH + 1);

	cc20_pkg::item_t  slot_q [cc20_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;

	assign in_ready   = (count_q != CNT_W'(cc20_pkg::QUEUE_DEPTH));
	assign push       = in_valid && in_ready;
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	// store accepted word with its restart mark
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{plaintext_word: plaintext_word, restart: restart};
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: src/cc20_core.sv
// ----------------------------------------------------------------------------
// cc20_core
// Keystream block engine: half a quarter-round on four lanes per cycle.
// ----------------------------------------------------------------------------
module cc20_core #(
	parameter int unsigned ROUND_COUNT = cc20_pkg::ROUND_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [255:0]         key,
	input  logic [95:0]          nonce,
	input  cc20_pkg::word_t      ctr,
	input  logic [3:0]           word_sel,
	output cc20_pkg::word_t      ks_word,
	output cc20_pkg::core_stat_t stat
);

	localparam int unsigned RND_W = $clog2(ROUND_COUNT);
	localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUND_COUNT - 1);

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_RUN  = 2'd1;
	localparam logic [1:0] C_ADD  = 2'd2;

	logic [1:0]       state_q;
	logic [RND_W-1:0] round_q;
	logic             half_q;
	cc20_pkg::word_t  ctr_q;
	cc20_pkg::blk_t   x_q;
	cc20_pkg::blk_t   x_d;
	cc20_pkg::blk_t   init;
	logic             diag;
	logic [3:0]       lane_a [4];
	logic [3:0]       lane_b [4];
	logic [3:0]       lane_c [4];
	logic [3:0]       lane_d [4];
	cc20_pkg::qr_t    lane_out [4];

	assign init    = cc20_pkg::build_state(key, nonce, ctr_q);
	assign diag    = round_q[0];
	assign ks_word = x_q[word_sel];
	assign stat    = '{busy: (state_q != C_IDLE), done: (state_q == C_ADD)};

	// pick lane words: columns, or diagonals on odd rounds
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			lane_a[j] = {2'b00, 2'(j)};
			lane_b[j] = {2'b01, 2'(j) + (diag ? 2'd1 : 2'd0)};
			lane_c[j] = {2'b10, 2'(j) + (diag ? 2'd2 : 2'd0)};
			lane_d[j] = {2'b11, 2'(j) + (diag ? 2'd3 : 2'd0)};
		end
	end

	// run the four lanes in parallel and scatter back
	always_comb begin
		x_d = x_q;
		for (int j = 0; j < 4; j++) begin
			lane_out[j] = cc20_pkg::qr_half('{a: x_q[lane_a[j]], b: x_q[lane_b[j]],
				c: x_q[lane_c[j]], d: x_q[lane_d[j]]}, half_q);
			x_d[lane_a[j]] = lane_out[j].a;
			x_d[lane_b[j]] = lane_out[j].b;
			x_d[lane_c[j]] = lane_out[j].c;
			x_d[lane_d[j]] = lane_out[j].d;
		end
	end

	// working state: load, round steps, add back the start state
	always_ff @(posedge clk) begin
		if (start && state_q == C_IDLE) begin
			x_q   <= cc20_pkg::build_state(key, nonce, ctr);
			ctr_q <= ctr;
		end else if (state_q == C_RUN) begin
			x_q <= x_d;
		end else if (state_q == C_ADD) begin
			for (int i = 0; i < 16; i++) begin
				x_q[i] <= x_q[i] + init[i];
			end
		end
	end

	// sequence rounds and halves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			round_q <= '0;
			half_q  <= 1'b0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_RUN;
						round_q <= '0;
						half_q  <= 1'b0;
					end
				end
				C_RUN: begin
					half_q <= !half_q;
					if (half_q) begin
						if (round_q == LAST_ROUND) begin
							state_q <= C_ADD;
						end else begin
							round_q <= round_q + RND_W'(1);
						end
					end
				end
				C_ADD: begin
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/cc20_back.sv
// ----------------------------------------------------------------------------
// cc20_back
// Output side: tracks word index and block counter, starts block generation,
// XORs each word with its keystream word into the output register.
// ----------------------------------------------------------------------------
`include "chacha20_stream_cipher_macros.svh"

module cc20_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  cc20_pkg::item_t      head,
	output logic                 pop,
	input  cc20_pkg::word_t      initial_counter,
	output logic                 core_start,
	output cc20_pkg::word_t      core_ctr,
	output logic [3:0]           word_sel,
	input  cc20_pkg::word_t      ks_word,
	input  cc20_pkg::core_stat_t core_stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cc20_pkg::word_t      ciphertext_word,
	output logic                 block_end
);

	localparam logic [1:0] BK_IDLE  = 2'd0;
	localparam logic [1:0] BK_GEN   = 2'd1;
	localparam logic [1:0] BK_READY = 2'd2;

	logic [1:0]      state_q;
	logic [3:0]      word_index_q;
	cc20_pkg::word_t block_counter_q;
	logic            out_valid_q;
	cc20_pkg::word_t ciphertext_q;
	logic            block_end_q;
	logic [3:0]      eff_idx;
	cc20_pkg::word_t eff_ctr;
	logic            slot_free;

	// restart applies before the word it comes with
	assign eff_idx    = head.restart ? 4'd0 : word_index_q;
	assign eff_ctr    = head.restart ? initial_counter : block_counter_q;
	assign slot_free  = !out_valid_q || out_ready;
	assign core_start = head_valid && (state_q == BK_IDLE) && (eff_idx == 4'd0);
	assign core_ctr   = eff_ctr;
	assign word_sel   = eff_idx;
	assign pop        = head_valid && slot_free &&
		(((state_q == BK_IDLE) && (eff_idx != 4'd0)) || (state_q == BK_READY));

	assign out_valid       = out_valid_q;
	assign ciphertext_word = ciphertext_q;
	assign block_end       = block_end_q;

	// hold result word until taken
	always_ff @(posedge clk) begin
		if (pop) begin
			ciphertext_q <= head.plaintext_word ^ ks_word;
			block_end_q  <= (eff_idx == 4'hf);
		end
	end

	// block sequencing, index and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= BK_IDLE;
			word_index_q    <= '0;
			block_counter_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (core_start) begin
						state_q <= BK_GEN;
					end
				end
				BK_GEN: begin
					if (core_stat.done) begin
						state_q <= BK_READY;
					end
				end
				BK_READY: begin
					if (pop) begin
						state_q <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
			if (pop) begin
				word_index_q    <= eff_idx + 4'd1;
				block_counter_q <= (eff_idx == 4'hf) ? eff_ctr + 32'd1 : eff_ctr;
				out_valid_q     <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`CC20_ASSERT_NOW(a_pop_core_idle, pop, !core_stat.busy, "word issued while core runs")
	`CC20_ASSERT_NOW(a_start_core_idle, core_start, !core_stat.busy, "core started while busy")
	`CC20_ASSERT_NOW(a_done_in_gen, core_stat.done, state_q == BK_GEN, "core done outside gen")
	`CC20_ASSERT_NEXT(a_wrap_index, pop && (eff_idx == 4'hf), word_index_q == 4'd0,
		"word index did not wrap after block end")

endmodule

// File: src/chacha20_stream_cipher.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 keystream XOR, one 32-bit word per transfer, APB register port.
// ----------------------------------------------------------------------------
// Channel  Handshake                 Payload
// in       in_valid / in_ready       plaintext_word, restart
// out      out_valid / out_ready     ciphertext_word, block_end
// cfg      psel/penable/pwrite/pready paddr, pwdata, prdata (64-bit, 8-byte map)
//
// The first word of each block waits for the core: the load, every round in two
// half-round steps, the add-back of the start state, then the issue. The other
// 15 words of the block issue one per cycle while words are queued and the
// output is not stalled. The four-entry input queue accepts words while the core
// runs or the output stalls, until it is full.
// Reset empties the queue and clears the word index, block counter, output valid and config registers.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher #(
	parameter int unsigned ROUND_COUNT = cc20_pkg::ROUND_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] plaintext_word,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] ciphertext_word,
	output logic        block_end,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [63:0]          key_part_0_q;
	logic [63:0]          key_part_1_q;
	logic [63:0]          key_part_2_q;
	logic [63:0]          key_part_3_q;
	logic [63:0]          nonce_low_q;
	logic [31:0]          nonce_high_q;
	logic [31:0]          initial_counter_q;
	logic [2:0]           reg_idx;
	logic                 head_valid;
	cc20_pkg::item_t      head;
	logic                 pop;
	logic                 core_start;
	cc20_pkg::word_t      core_ctr;
	logic [3:0]           word_sel;
	cc20_pkg::word_t      ks_word;
	cc20_pkg::core_stat_t core_stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_part_0_q      <= '0;
			key_part_1_q      <= '0;
			key_part_2_q      <= '0;
			key_part_3_q      <= '0;
			nonce_low_q       <= '0;
			nonce_high_q      <= '0;
			initial_counter_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				cc20_pkg::REG_KEY_PART_0:      key_part_0_q      <= pwdata;
				cc20_pkg::REG_KEY_PART_1:      key_part_1_q      <= pwdata;
				cc20_pkg::REG_KEY_PART_2:      key_part_2_q      <= pwdata;
				cc20_pkg::REG_KEY_PART_3:      key_part_3_q      <= pwdata;
				cc20_pkg::REG_NONCE_LOW:       nonce_low_q       <= pwdata;
				cc20_pkg::REG_NONCE_HIGH:      nonce_high_q      <= pwdata[31:0];
				cc20_pkg::REG_INITIAL_COUNTER: initial_counter_q <= pwdata[31:0];
				default: begin
				end
			endcase
		end
	end

	// read back registers
	always_comb begin
		case (reg_idx)
			cc20_pkg::REG_KEY_PART_0:      prdata = key_part_0_q;
			cc20_pkg::REG_KEY_PART_1:      prdata = key_part_1_q;
			cc20_pkg::REG_KEY_PART_2:      prdata = key_part_2_q;
			cc20_pkg::REG_KEY_PART_3:      prdata = key_part_3_q;
			cc20_pkg::REG_NONCE_LOW:       prdata = nonce_low_q;
			cc20_pkg::REG_NONCE_HIGH:      prdata = {32'd0, nonce_high_q};
			cc20_pkg::REG_INITIAL_COUNTER: prdata = {32'd0, initial_counter_q};
			default:                       prdata = '0;
		endcase
	end

	cc20_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.plaintext_word (plaintext_word),
		.restart        (restart),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop)
	);

	cc20_core #(
		.ROUND_COUNT (ROUND_COUNT)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (core_start),
		.key      ({key_part_3_q, key_part_2_q, key_part_1_q, key_part_0_q}),
		.nonce    ({nonce_high_q, nonce_low_q}),
		.ctr      (core_ctr),
		.word_sel (word_sel),
		.ks_word  (ks_word),
		.stat     (core_stat)
	);

	cc20_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (head_valid),
		.head            (head),
		.pop             (pop),
		.initial_counter (initial_counter_q),
		.core_start      (core_start),
		.core_ctr        (core_ctr),
		.word_sel        (word_sel),
		.ks_word         (ks_word),
		.core_stat       (core_stat),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.ciphertext_word (ciphertext_word),
		.block_end       (block_end)
	);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks chacha20_stream_cipher word by word against a behavioral keystream
// predictor, through directed cases, a receiver hold-off and random streams.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned ROUNDS        = 20;
	localparam int unsigned SETTLE_CYCLES = 2 * ROUNDS + 24;
	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned RANDOM_WORDS  = 1700;
	localparam int unsigned REPORT_LIMIT  = 10;

	localparam logic [2:0] REG_LIST [7] = '{cc20_pkg::REG_KEY_PART_0,
		cc20_pkg::REG_KEY_PART_1, cc20_pkg::REG_KEY_PART_2, cc20_pkg::REG_KEY_PART_3,
		cc20_pkg::REG_NONCE_LOW, cc20_pkg::REG_NONCE_HIGH, cc20_pkg::REG_INITIAL_COUNTER};

	typedef struct packed {
		cc20_pkg::word_t ciphertext;
		logic            last;
	} cipher_word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] plaintext_word;
	logic        restart;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] ciphertext_word;
	logic        block_end;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	// predictor copy of the registers and the stream state
	logic [63:0]     key_m [4];
	logic [63:0]     nonce_lo_m;
	cc20_pkg::word_t nonce_hi_m;
	cc20_pkg::word_t init_ctr_m;
	cc20_pkg::word_t ctr_m;
	logic [3:0]      pos_m;
	cc20_pkg::blk_t  ks_m;

	cipher_word_t cipher_words_due [$];

	int unsigned mismatch_count;
	int unsigned words_sent;
	int unsigned words_checked;
	int unsigned blocks_seen;
	int unsigned restarts_sent;
	int unsigned phases_run;
	int unsigned cycle_count;
	int unsigned hold_request;
	bit          send_quiet;
	bit          recv_quiet;

	chacha20_stream_cipher #(
		.ROUND_COUNT(ROUNDS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.plaintext_word(plaintext_word),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ciphertext_word(ciphertext_word),
		.block_end(block_end),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("chacha20_stream_cipher: mismatch");
			$finish;
		end
	end

	function automatic cc20_pkg::word_t rot32(input cc20_pkg::word_t x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [127:0] quarter_round(input cc20_pkg::word_t a,
			input cc20_pkg::word_t b, input cc20_pkg::word_t c, input cc20_pkg::word_t d);
		a = a + b; d = rot32(d ^ a, 16);
		c = c + d; b = rot32(b ^ c, 12);
		a = a + b; d = rot32(d ^ a, 8);
		c = c + d; b = rot32(b ^ c, 7);
		return {a, b, c, d};
	endfunction

	// one keystream block from the current registers and a block counter
	function automatic cc20_pkg::blk_t keystream_block(input cc20_pkg::word_t ctr);
		cc20_pkg::blk_t st;
		cc20_pkg::blk_t w;
		st[0] = cc20_pkg::SIGMA_0;
		st[1] = cc20_pkg::SIGMA_1;
		st[2] = cc20_pkg::SIGMA_2;
		st[3] = cc20_pkg::SIGMA_3;
		for (int i = 0; i < 4; i++) begin
			st[4 + 2*i] = key_m[i][31:0];
			st[5 + 2*i] = key_m[i][63:32];
		end
		st[12] = ctr;
		st[13] = nonce_lo_m[31:0];
		st[14] = nonce_lo_m[63:32];
		st[15] = nonce_hi_m;
		w = st;
		for (int r = 0; r < ROUNDS; r++) begin
			if (r % 2 == 0) begin
				{w[0], w[4], w[8], w[12]} = quarter_round(w[0], w[4], w[8], w[12]);
				{w[1], w[5], w[9], w[13]} = quarter_round(w[1], w[5], w[9], w[13]);
				{w[2], w[6], w[10], w[14]} = quarter_round(w[2], w[6], w[10], w[14]);
				{w[3], w[7], w[11], w[15]} = quarter_round(w[3], w[7], w[11], w[15]);
			end else begin
				{w[0], w[5], w[10], w[15]} = quarter_round(w[0], w[5], w[10], w[15]);
				{w[1], w[6], w[11], w[12]} = quarter_round(w[1], w[6], w[11], w[12]);
				{w[2], w[7], w[8], w[13]} = quarter_round(w[2], w[7], w[8], w[13]);
				{w[3], w[4], w[9], w[14]} = quarter_round(w[3], w[4], w[9], w[14]);
			end
		end
		for (int i = 0; i < 16; i++) begin
			st[i] = w[i] + st[i];
		end
		return st;
	endfunction

	// advance the predicted stream by one word and queue its ciphertext
	task automatic predict_cipher_word(input cc20_pkg::word_t pt, input logic rs);
		cipher_word_t exp;
		if (rs) begin
			ctr_m = init_ctr_m;
			pos_m = 4'd0;
		end
		if (pos_m == 4'd0) begin
			ks_m = keystream_block(ctr_m);
		end
		exp.ciphertext = pt ^ ks_m[pos_m];
		exp.last = (pos_m == 4'd15);
		pos_m = pos_m + 4'd1;
		if (pos_m == 4'd0) begin
			ctr_m = ctr_m + 32'd1;
		end
		cipher_words_due.push_back(exp);
	endtask

	task automatic note_mismatch(input string what, input logic [63:0] exp,
			input logic [63:0] act);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("[%0t] %s: expected %h, got %h", $realtime, what, exp, act);
		end
	endtask

	function automatic int unsigned draw_wait(input bit quiet);
		return quiet ? 0 : $urandom_range(0, 12);
	endfunction

	// offer one word, hold it until accepted
	task automatic send_word(input cc20_pkg::word_t pt, input logic rs);
		int unsigned gap;
		gap = draw_wait(send_quiet);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       <= 1'b1;
		plaintext_word <= pt;
		restart        <= rs;
		do @(posedge clk); while (!in_ready);
		predict_cipher_word(pt, rs);
		words_sent++;
		if (rs) begin
			restarts_sent++;
		end
	endtask

	// drop valid and wait until every queued word has come back
	task automatic drain_words();
		@(negedge clk);
		in_valid <= 1'b0;
		while (cipher_words_due.size() != 0) @(posedge clk);
	endtask

	task automatic apb_read(input logic [2:0] idx, output logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 3'b000};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [63:0] reg_mask(input logic [2:0] idx);
		return (idx == cc20_pkg::REG_NONCE_HIGH || idx == cc20_pkg::REG_INITIAL_COUNTER) ?
			64'h0000_0000_FFFF_FFFF : '1;
	endfunction

	function automatic logic [63:0] model_reg(input logic [2:0] idx);
		case (idx)
			cc20_pkg::REG_KEY_PART_0:      return key_m[0];
			cc20_pkg::REG_KEY_PART_1:      return key_m[1];
			cc20_pkg::REG_KEY_PART_2:      return key_m[2];
			cc20_pkg::REG_KEY_PART_3:      return key_m[3];
			cc20_pkg::REG_NONCE_LOW:       return nonce_lo_m;
			cc20_pkg::REG_NONCE_HIGH:      return {32'h0, nonce_hi_m};
			cc20_pkg::REG_INITIAL_COUNTER: return {32'h0, init_ctr_m};
			default:                       return '0;
		endcase
	endfunction

	task automatic check_reg(input logic [2:0] idx);
		logic [63:0] value;
		apb_read(idx, value);
		if ((value & reg_mask(idx)) !== model_reg(idx)) begin
			note_mismatch($sformatf("register %0d readback", idx), model_reg(idx),
				value & reg_mask(idx));
		end
	endtask

	// write one register, mirror it in the predictor and read it back
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			cc20_pkg::REG_KEY_PART_0:      key_m[0] = value;
			cc20_pkg::REG_KEY_PART_1:      key_m[1] = value;
			cc20_pkg::REG_KEY_PART_2:      key_m[2] = value;
			cc20_pkg::REG_KEY_PART_3:      key_m[3] = value;
			cc20_pkg::REG_NONCE_LOW:       nonce_lo_m = value;
			cc20_pkg::REG_NONCE_HIGH:      nonce_hi_m = value[31:0];
			cc20_pkg::REG_INITIAL_COUNTER: init_ctr_m = value[31:0];
			default:                       ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		check_reg(idx);
	endtask

	// style: 0 all zero, 1 all ones, 2 random, 3 random with counter near wrap
	function automatic logic [63:0] pick_value(input int unsigned style);
		case (style)
			0:       return '0;
			1:       return '1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	task automatic write_all_regs(input int unsigned style);
		for (int i = 0; i < 7; i++) begin
			if (REG_LIST[i] == cc20_pkg::REG_INITIAL_COUNTER && style == 3) begin
				write_reg(REG_LIST[i], {32'h0, 32'hFFFF_FFFF - $urandom_range(0, 2)});
			end else begin
				write_reg(REG_LIST[i], pick_value(style));
			end
		end
	endtask

	// take output words, stall at random, check each one in order
	initial begin
		cipher_word_t exp;
		int unsigned stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(recv_quiet);
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (cipher_words_due.size() == 0) begin
				note_mismatch("unexpected word", '0, {31'h0, block_end, ciphertext_word});
			end else begin
				exp = cipher_words_due.pop_front();
				words_checked++;
				if (ciphertext_word !== exp.ciphertext) begin
					note_mismatch($sformatf("ciphertext_word #%0d", words_checked),
						64'(exp.ciphertext), 64'(ciphertext_word));
				end
				if (block_end !== exp.last) begin
					note_mismatch($sformatf("block_end #%0d", words_checked),
						64'(exp.last), 64'(block_end));
				end
			end
			if (block_end === 1'b1) begin
				blocks_seen++;
			end
		end
	end

	// reset values, counter 0, plaintext extremes
	task automatic test_reset_values();
		for (int i = 0; i < 7; i++) begin
			check_reg(REG_LIST[i]);
		end
		send_word(32'h0000_0000, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word($urandom(), 1'b0);
		drain_words();
	endtask

	// start one block before the counter wraps and run into the next block
	task automatic test_counter_wrap();
		write_all_regs(2);
		write_reg(cc20_pkg::REG_INITIAL_COUNTER, 64'h0000_0000_FFFF_FFFF);
		for (int k = 0; k < 18; k++) begin
			send_word((k % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000, k == 0);
		end
		drain_words();
	endtask

	// restart inside a block, with all registers at their maximum
	task automatic test_restart_mid_block();
		write_all_regs(1);
		send_word($urandom(), 1'b1);
		send_word($urandom(), 1'b0);
		send_word($urandom(), 1'b0);
		send_word($urandom(), 1'b1);
		send_word($urandom(), 1'b0);
		drain_words();
	endtask

	// hold the receiver off long enough to fill the input queue and stall its input
	task automatic test_backpressure();
		write_all_regs(2);
		send_quiet   = 1'b1;
		hold_request = 400;
		for (int k = 0; k < 48; k++) begin
			send_word($urandom(), k == 0);
		end
		drain_words();
		send_quiet = 1'b0;
	endtask

	// random phases of random settings, mostly plain streams with rare restarts
	task automatic test_random_stream();
		int unsigned sent;
		int unsigned style;
		int unsigned len;
		logic        rs;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			phases_run++;
			style = (phases_run <= 2) ? phases_run - 1 : $urandom_range(0, 3);
			if (phases_run <= 4 || $urandom_range(0, 3) != 0) begin
				write_all_regs(style);
			end
			send_quiet = ($urandom_range(0, 4) == 0);
			recv_quiet = ($urandom_range(0, 4) == 0);
			len = $urandom_range(20, 120);
			for (int unsigned k = 0; k < len; k++) begin
				if (k == 0) begin
					rs = ($urandom_range(0, 3) != 0);
				end else begin
					rs = ($urandom_range(0, 31) == 0);
				end
				send_word($urandom(), rs);
			end
			sent += len;
			drain_words();
		end
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		plaintext_word = '0;
		restart        = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		key_m          = '{default: '0};
		nonce_lo_m     = '0;
		nonce_hi_m     = '0;
		init_ctr_m     = '0;
		ctr_m          = '0;
		pos_m          = '0;
		ks_m           = '0;
		mismatch_count = 0;
		words_sent     = 0;
		words_checked  = 0;
		blocks_seen    = 0;
		restarts_sent  = 0;
		phases_run     = 0;
		cycle_count    = 0;
		hold_request   = 0;
		send_quiet     = 1'b0;
		recv_quiet     = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_counter_wrap();
		test_restart_mid_block();
		test_backpressure();
		test_random_stream();

		// let the pipeline settle, then flag anything still owed
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (cipher_words_due.size() != 0) begin
			note_mismatch("words never returned", 64'(cipher_words_due.size()), '0);
		end

		$display("Sent %0d words (%0d restarts) over %0d random phases plus directed cases.",
			words_sent, restarts_sent, phases_run);
		$display("Checked %0d words, %0d full keystream blocks, %0d mismatches.",
			words_checked, blocks_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("chacha20_stream_cipher: match");
		end else begin
			$display("chacha20_stream_cipher: mismatch");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/cc20_pkg.sv
src/cc20_front.sv
src/cc20_core.sv
src/cc20_back.sv
src/chacha20_stream_cipher.sv
tb/testbench.sv
